// File: rtl/core/zone_time_statistics_table_unit_macros.svh
// Assertion macros for the zone time statistics table.
// No dependencies; included by the top level only.
`ifndef ZONE_TIME_STATISTICS_TABLE_UNIT_MACROS_SVH
`define ZONE_TIME_STATISTICS_TABLE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ZTS_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define ZTS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: rtl/core/zts_pkg.sv
// Package for the zone time statistics table: widths, commands, FSM states,
// controller/datapath command and status structs. No dependencies.
package zts_pkg;
  localparam int MaxZonesDef = 48;
  localparam int LabelW = 16;
  localparam int DurW = 32;
  localparam int LevelW = 6;
  localparam int TotalW = 48;
  localparam int CountW = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_INSERT,
    ST_ROOT,
    ST_SCAN,
    ST_PICK,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic start_cmd;   // latch input beat
    logic scan_clr;    // reset scan index
    logic scan_inc;    // step scan index
    logic hit_upd;     // update hit entry
    logic ins_new;     // append entry
    logic frame_inc;
    logic root_acc;    // accumulate root max from current read
    logic best_acc;    // compare current read against best
    logic best_clr;
    logic mark_best;   // mark best entry emitted
    logic load_out;    // load output register from best entry
    logic clear_all;
    logic rd_best;     // read address is best index
  } ctl_t;

  typedef struct packed {
    logic scan_done;   // scan index past last entry
    logic hit;
    logic full;
    logic lbl_zero;
    logic empty;
    logic emit_done;   // beat being emitted is the last entry
    logic out_busy;    // output register holds a stalled beat
    cmd_t cmd;
  } sts_t;
endpackage

// File: rtl/core/zts_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module zts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/zts_ctrl.sv
// Controller FSM for the zone time statistics table.
// Depends on zts_pkg.
module zts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  zts_pkg::sts_t sts,
  output zts_pkg::ctl_t ctl
);
  zts_pkg::state_t state_r, state_nxt;
  logic            prim_r, prim_nxt;  // read pipeline primed

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zts_pkg::ST_IDLE;
      prim_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prim_r  <= prim_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    prim_nxt  = 1'b0;
    case (state_r)
      zts_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = zts_pkg::ST_SEARCH;
        end
      end
      zts_pkg::ST_SEARCH: begin
        case (sts.cmd)
          zts_pkg::CMD_ADD: begin
            prim_nxt = 1'b1;
            if (sts.lbl_zero) begin
              state_nxt = zts_pkg::ST_IDLE;
            end else if (prim_r && sts.hit) begin
              state_nxt = zts_pkg::ST_UPDATE;
            end else if (sts.scan_done) begin
              state_nxt = sts.full ? zts_pkg::ST_IDLE : zts_pkg::ST_INSERT;
            end
          end
          zts_pkg::CMD_REPORT: begin
            state_nxt = sts.empty ? zts_pkg::ST_IDLE : zts_pkg::ST_ROOT;
          end
          default: state_nxt = zts_pkg::ST_IDLE;
        endcase
      end
      zts_pkg::ST_UPDATE: state_nxt = zts_pkg::ST_IDLE;
      zts_pkg::ST_INSERT: state_nxt = zts_pkg::ST_IDLE;
      zts_pkg::ST_ROOT: begin
        prim_nxt = 1'b1;
        if (prim_r && sts.scan_done) begin
          state_nxt = zts_pkg::ST_SCAN;
        end
      end
      zts_pkg::ST_SCAN: begin
        prim_nxt = 1'b1;
        if (prim_r && sts.scan_done) begin
          state_nxt = zts_pkg::ST_PICK;
        end
      end
      zts_pkg::ST_PICK: state_nxt = zts_pkg::ST_EMIT;
      zts_pkg::ST_EMIT: begin
        if (!sts.out_busy) begin
          state_nxt = sts.emit_done ? zts_pkg::ST_CLEAR : zts_pkg::ST_SCAN;
        end
      end
      zts_pkg::ST_CLEAR: state_nxt = zts_pkg::ST_IDLE;
      default: state_nxt = zts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_stall = (state_r != zts_pkg::ST_IDLE);
    case (state_r)
      zts_pkg::ST_IDLE: begin
        ctl.start_cmd = in_valid;
        ctl.scan_clr  = 1'b1;
      end
      zts_pkg::ST_SEARCH: begin
        if (sts.cmd == zts_pkg::CMD_ADD) begin
          if (!(prim_r && sts.hit) && !sts.scan_done) begin
            ctl.scan_inc = 1'b1;
          end
        end else if (sts.cmd == zts_pkg::CMD_FRAME) begin
          ctl.frame_inc = 1'b1;
        end
      end
      zts_pkg::ST_UPDATE: ctl.hit_upd = 1'b1;
      zts_pkg::ST_INSERT: ctl.ins_new = 1'b1;
      zts_pkg::ST_ROOT: begin
        ctl.root_acc = prim_r;
        ctl.best_clr = 1'b1;
        if (prim_r && sts.scan_done) begin
          ctl.scan_clr = 1'b1;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      zts_pkg::ST_SCAN: begin
        ctl.best_acc = prim_r;
        if (!(prim_r && sts.scan_done)) begin
          ctl.scan_inc = 1'b1;
        end
      end
      zts_pkg::ST_PICK: ctl.rd_best = 1'b1;
      zts_pkg::ST_EMIT: begin
        ctl.rd_best = 1'b1;
        if (!sts.out_busy) begin
          ctl.load_out  = 1'b1;
          ctl.mark_best = 1'b1;
          ctl.best_clr  = 1'b1;
          ctl.scan_clr  = 1'b1;
        end
      end
      zts_pkg::ST_CLEAR: ctl.clear_all = 1'b1;
      default: ;
    endcase
  end
endmodule

// File: rtl/core/zts_dp.sv
// Datapath for the zone time statistics table: entry RAM, scan index,
// accumulators, sort selection and output register. Depends on zts_pkg, zts_ram.
module zts_dp #(
  parameter int MaxZones = zts_pkg::MaxZonesDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_cmd,
  input  logic [zts_pkg::LabelW-1:0]   in_zone_label,
  input  logic [zts_pkg::DurW-1:0]     in_duration_us,
  input  logic [zts_pkg::LevelW-1:0]   in_nest_level,
  input  zts_pkg::ctl_t                ctl,
  output zts_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [zts_pkg::LabelW-1:0]   out_label,
  output logic [zts_pkg::LevelW-1:0]   out_level,
  output logic [zts_pkg::TotalW-1:0]   out_total_us,
  output logic [zts_pkg::DurW-1:0]     out_peak_us,
  output logic [zts_pkg::CountW-1:0]   out_calls,
  output logic [zts_pkg::CountW-1:0]   out_frames,
  output logic [zts_pkg::TotalW-1:0]   out_root_total_us,
  output logic                         out_last
);
  localparam int AW = (MaxZones > 1) ? $clog2(MaxZones) : 1;
  localparam int CW = $clog2(MaxZones + 1);
  localparam int EW = zts_pkg::LabelW + zts_pkg::TotalW + zts_pkg::DurW
                      + zts_pkg::CountW + zts_pkg::LevelW;
  localparam logic [zts_pkg::TotalW-1:0] TotMax = '1;
  localparam logic [zts_pkg::CountW-1:0] CntMax = '1;

  typedef struct packed {
    logic [zts_pkg::LabelW-1:0] label;
    logic [zts_pkg::TotalW-1:0] total;
    logic [zts_pkg::DurW-1:0]   peak;
    logic [zts_pkg::CountW-1:0] calls;
    logic [zts_pkg::LevelW-1:0] level;
  } entry_t;

  zts_pkg::cmd_t              cmd_r;
  logic [zts_pkg::LabelW-1:0] lbl_r;
  logic [zts_pkg::DurW-1:0]   dur_r;
  logic [zts_pkg::LevelW-1:0] lvl_r;
  logic [CW-1:0]              cnt_r, idx_r, ridx_r, emitted_r;
  logic [zts_pkg::CountW-1:0] frames_r;
  logic [zts_pkg::TotalW-1:0] root_r, best_tot_r;
  logic [AW-1:0]              best_r, hit_idx_r;
  logic                       best_ok_r;
  logic [zts_pkg::TotalW-1:0] prev_tot_r;  // total of last emitted entry
  logic [AW-1:0]              prev_idx_r;
  logic                       prev_ok_r;
  logic                       elig;        // entry ranks below last emitted one
  entry_t                     rd, wr, hit_e_r;
  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic [zts_pkg::TotalW:0]   sum;
  logic                       ovalid_r;
  entry_t                     oe_r;
  logic [zts_pkg::CountW-1:0] ofr_r;
  logic [zts_pkg::TotalW-1:0] oroot_r;
  logic                       olast_r;
  logic                       rd_ok;

  zts_ram #(.Width(EW), .Depth(MaxZones)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr), .raddr(raddr), .rdata(rd)
  );

  assign raddr = ctl.rd_best ? best_r : idx_r[AW-1:0];
  assign rd_ok = (ridx_r < cnt_r);
  assign sum = {1'b0, hit_e_r.total} + {{(zts_pkg::TotalW-zts_pkg::DurW+1){1'b0}}, dur_r};
  assign elig = !prev_ok_r || (rd.total < prev_tot_r)
                || ((rd.total == prev_tot_r) && (ridx_r[AW-1:0] > prev_idx_r));

  always_comb begin
    we    = ctl.hit_upd | ctl.ins_new;
    waddr = ctl.hit_upd ? hit_idx_r : cnt_r[AW-1:0];
    wr    = hit_e_r;
    if (ctl.hit_upd) begin
      wr.total = sum[zts_pkg::TotalW] ? TotMax : sum[zts_pkg::TotalW-1:0];
      if (dur_r > hit_e_r.peak) begin
        wr.peak = dur_r;
      end
      if (hit_e_r.calls != CntMax) begin
        wr.calls = hit_e_r.calls + 1'b1;
      end
    end else begin
      wr.label = lbl_r;
      wr.total = {{(zts_pkg::TotalW-zts_pkg::DurW){1'b0}}, dur_r};
      wr.peak  = dur_r;
      wr.calls = {{(zts_pkg::CountW-1){1'b0}}, 1'b1};
      wr.level = lvl_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.cmd        = cmd_r;
    sts.scan_done  = (idx_r >= cnt_r) && (ridx_r >= cnt_r);
    sts.hit        = rd_ok && (rd.label == lbl_r);
    sts.full       = (cnt_r >= CW'(MaxZones));
    sts.lbl_zero   = (lbl_r == '0);
    sts.empty      = (cnt_r == '0);
    sts.emit_done  = (CW'(emitted_r + 1'b1) == cnt_r);
    sts.out_busy   = ovalid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      frames_r  <= '0;
      ovalid_r  <= 1'b0;
      idx_r     <= '0;
      ridx_r    <= '0;
      emitted_r <= '0;
      best_ok_r <= 1'b0;
      prev_ok_r <= 1'b0;
    end else begin
      if (ctl.load_out) begin
        ovalid_r <= 1'b1;
      end else if (ovalid_r && !out_stall) begin
        ovalid_r <= 1'b0;
      end
      if (ctl.scan_clr) begin
        idx_r  <= '0;
        ridx_r <= CW'(MaxZones);
      end else if (ctl.scan_inc) begin
        if (idx_r < cnt_r) begin
          idx_r <= idx_r + 1'b1;
        end
        ridx_r <= (idx_r < cnt_r) ? idx_r : CW'(MaxZones);
      end else begin
        ridx_r <= CW'(MaxZones);
      end
      if (ctl.ins_new) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.frame_inc && frames_r != CntMax) begin
        frames_r <= frames_r + 1'b1;
      end
      if (ctl.best_clr) begin
        best_ok_r <= 1'b0;
      end else if (ctl.best_acc && rd_ok && elig
                   && (!best_ok_r || rd.total > best_tot_r)) begin
        best_ok_r <= 1'b1;
      end
      if (ctl.start_cmd) begin
        prev_ok_r <= 1'b0;
      end
      if (ctl.mark_best) begin
        prev_ok_r <= 1'b1;
        emitted_r <= emitted_r + 1'b1;
      end
      if (ctl.clear_all) begin
        cnt_r     <= '0;
        frames_r  <= '0;
        emitted_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_cmd) begin
      cmd_r  <= zts_pkg::cmd_t'(in_cmd);
      lbl_r  <= in_zone_label;
      dur_r  <= in_duration_us;
      lvl_r  <= in_nest_level;
      root_r <= '0;
    end
    if (sts.hit && !ctl.hit_upd) begin
      hit_e_r   <= rd;
      hit_idx_r <= ridx_r[AW-1:0];
    end
    if (ctl.root_acc && rd_ok && rd.level == '0 && rd.total > root_r) begin
      root_r <= rd.total;
    end
    if (ctl.best_acc && rd_ok && elig
        && (!best_ok_r || rd.total > best_tot_r)) begin
      best_r     <= ridx_r[AW-1:0];
      best_tot_r <= rd.total;
    end
    if (ctl.mark_best) begin
      prev_tot_r <= best_tot_r;
      prev_idx_r <= best_r;
    end
    if (ctl.load_out) begin
      oe_r    <= rd;
      ofr_r   <= frames_r;
      oroot_r <= root_r;
      olast_r <= sts.emit_done;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_label         = oe_r.label;
  assign out_level         = oe_r.level;
  assign out_total_us      = oe_r.total;
  assign out_peak_us       = oe_r.peak;
  assign out_calls         = oe_r.calls;
  assign out_frames        = ofr_r;
  assign out_root_total_us = oroot_r;
  assign out_last          = olast_r;
endmodule

// File: rtl/core/zone_time_statistics_table_unit.sv
// Top level of the zone time statistics table: controller plus datapath.
// Depends on zts_pkg, zts_ctrl, zts_dp and the macros header.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   cmd, zone_label, duration_us, nest_level
//  out_     output     out_valid/out_stall label, level, totals, peak, calls, frames, last
//
// A sample scans the table one entry a cycle; in_stall stays high until it is done.
// A frame beat, a zero-label sample, an unused command or an empty report skips the scan.
// A report of n entries spends one scan for the depth-0 maximum, then one selection
// scan per emitted beat.
// Reset clears counts; the entry RAM is not cleared. Output stall holds the report;
// a beat still stalled when the next one is selected delays its load.
`include "zone_time_statistics_table_unit_macros.svh"
module zone_time_statistics_table_unit #(
  parameter int MaxZones = zts_pkg::MaxZonesDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_cmd,
  input  logic [zts_pkg::LabelW-1:0] in_zone_label,
  input  logic [zts_pkg::DurW-1:0]   in_duration_us,
  input  logic [zts_pkg::LevelW-1:0] in_nest_level,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [zts_pkg::LabelW-1:0] out_label,
  output logic [zts_pkg::LevelW-1:0] out_level,
  output logic [zts_pkg::TotalW-1:0] out_total_us,
  output logic [zts_pkg::DurW-1:0]   out_peak_us,
  output logic [zts_pkg::CountW-1:0] out_calls,
  output logic [zts_pkg::CountW-1:0] out_frames,
  output logic [zts_pkg::TotalW-1:0] out_root_total_us,
  output logic                       out_last
);
  zts_pkg::ctl_t ctl;
  zts_pkg::sts_t sts;

  zts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .ctl(ctl)
  );

  zts_dp #(.MaxZones(MaxZones)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_cmd(in_cmd), .in_zone_label(in_zone_label),
    .in_duration_us(in_duration_us), .in_nest_level(in_nest_level),
    .ctl(ctl), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_label(out_label), .out_level(out_level), .out_total_us(out_total_us),
    .out_peak_us(out_peak_us), .out_calls(out_calls), .out_frames(out_frames),
    .out_root_total_us(out_root_total_us), .out_last(out_last)
  );

  `ZTS_ASSERT_IMPL(a_load_no_wr, clk, rst_n, ctl.load_out, !(ctl.hit_upd || ctl.ins_new), "wr on load")
  `ZTS_ASSERT_NEXT(a_ins_idle, clk, rst_n, ctl.ins_new, !in_stall || !sts.empty, "insert lost")
  `ZTS_ASSERT_IMPL(a_load_free, clk, rst_n, ctl.load_out, !sts.out_busy, "output overwritten")
endmodule
